/* sv/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg: shared constants and functions for the quaternion to Euler angles block
// Holds the fixed-point widths, the angle limits and the CORDIC stage angles,
// which are worked out at elaboration from integer arctangent series.
// ----------------------------------------------------------------------------
package q2e_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_QUAT_WIDTH    = 16;
    localparam int DEF_CORDIC_STAGES = 16;

    // Internal widths
    localparam int PROD_W   = 32;   // one product in Q28
    localparam int TW       = 36;   // atan2 operands in Q28
    localparam int CLIP_W   = 30;   // clamped pitch sine in Q28, holds +-1.0
    localparam int SQR_W    = 60;   // square of the clamped sine
    localparam int SQ_IN_W  = 57;   // radicand 1 - t^2 in Q56
    localparam int SQ_BITS  = 29;   // bits of the square root (Q28, up to 1.0)
    localparam int XW       = 38;   // CORDIC vector width
    localparam int ZW       = 33;   // CORDIC angle width, Q29
    localparam int OUT_W    = 48;   // packed result width

    localparam int ROLL_LIM  = 25736;
    localparam int PITCH_LIM = 12868;

    localparam logic signed [TW-1:0] ONE_Q28 = TW'(64'd1 << 28);

    // atan(2^-sh) in Q60 from its alternating series, sh >= 1
    function automatic longint unsigned atan_pow2_q60(input int unsigned sh);
        longint unsigned p;
        longint unsigned sum;
        int unsigned     k;
        p   = 64'd1 << (60 - sh);
        sum = 64'd0;
        for (k = 0; k < 64; k++)
        begin
            if (p != 64'd0)
            begin
                if (k[0] == 1'b0)
                    sum = sum + p / 64'(2 * k + 1);
                else
                    sum = sum - p / 64'(2 * k + 1);
                p = p >> (2 * sh);
            end
        end
        return sum;
    endfunction

    // atan(1/5) in Q60
    function automatic longint unsigned atan_inv5_q60();
        longint unsigned p;
        longint unsigned sum;
        int unsigned     k;
        p   = (64'd1 << 60) / 64'd5;
        sum = 64'd0;
        for (k = 0; k < 64; k++)
        begin
            if (p != 64'd0)
            begin
                if (k[0] == 1'b0)
                    sum = sum + p / 64'(2 * k + 1);
                else
                    sum = sum - p / 64'(2 * k + 1);
                p = p / 64'd25;
            end
        end
        return sum;
    endfunction

    // atan(1/239) in Q60
    function automatic longint unsigned atan_inv239_q60();
        longint unsigned p;
        longint unsigned sum;
        int unsigned     k;
        p   = (64'd1 << 60) / 64'd239;
        sum = 64'd0;
        for (k = 0; k < 64; k++)
        begin
            if (p != 64'd0)
            begin
                if (k[0] == 1'b0)
                    sum = sum + p / 64'(2 * k + 1);
                else
                    sum = sum - p / 64'(2 * k + 1);
                p = p / 64'd57121;
            end
        end
        return sum;
    endfunction

    // Stage angle atan(2^-i) in Q29, rounded half up from Q60
    function automatic logic signed [ZW-1:0] cordic_angle(input int unsigned i);
        longint unsigned a;
        if (i == 0)
            a = 64'd4 * atan_inv5_q60() - atan_inv239_q60();
        else
            a = atan_pow2_q60(i);
        return ZW'((a + (64'd1 << 30)) >> 31);
    endfunction

    localparam logic signed [ZW-1:0] HALF_PI_Q29 = ZW'(cordic_angle(0) <<< 1);

    // Angle from Q29 to Q13, rounded half away from zero, then clamped
    function automatic logic signed [15:0] angle_q13(input logic signed [ZW-1:0] z,
                                                     input int lim);
        logic [ZW-1:0] mag;
        logic [ZW-1:0] r;
        logic [15:0]   c;
        mag = z[ZW-1] ? ZW'(-z) : ZW'(z);
        r   = (mag + ZW'(1 << 15)) >> 16;
        c   = (r > ZW'(lim)) ? 16'(lim) : 16'(r);
        return z[ZW-1] ? $signed(-c) : $signed(c);
    endfunction

endpackage

/* sv/q2e_front.sv */
// ----------------------------------------------------------------------------
// q2e_front: products and atan2 operands
// Three register stages: the nine component products in Q28, the five
// operands with the pitch sine clamped, and the radicand 1 - t^2.
// ----------------------------------------------------------------------------
module q2e_front
    import q2e_pkg::*;
#(
    parameter int QUAT_WIDTH = DEF_QUAT_WIDTH
)
(
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [QUAT_WIDTH-1:0] quat_x,
    input  logic signed [QUAT_WIDTH-1:0] quat_y,
    input  logic signed [QUAT_WIDTH-1:0] quat_z,
    input  logic signed [QUAT_WIDTH-1:0] quat_w,
    output logic signed [TW-1:0]         t0,
    output logic signed [TW-1:0]         t1,
    output logic signed [CLIP_W-1:0]     t2,
    output logic signed [TW-1:0]         t3,
    output logic signed [TW-1:0]         t4,
    output logic [SQ_IN_W-1:0]           sq
);

    localparam int FB = 2 * (QUAT_WIDTH - 2);
    localparam int NPROD = 9;
    localparam int P_WX = 0, P_YZ = 1, P_XX = 2, P_YY = 3, P_WY = 4;
    localparam int P_ZX = 5, P_WZ = 6, P_XY = 7, P_ZZ = 8;

    logic signed [QUAT_WIDTH-1:0] opa [NPROD];
    logic signed [QUAT_WIDTH-1:0] opb [NPROD];
    logic signed [PROD_W-1:0]     prod [NPROD];
    logic signed [PROD_W-1:0]     prod_reg [NPROD];

    logic signed [TW-1:0]     t0_next, t1_next, t3_next, t4_next, t2_raw;
    logic signed [CLIP_W-1:0] t2_next;
    logic signed [TW-1:0]     t0_reg, t1_reg, t3_reg, t4_reg;
    logic signed [CLIP_W-1:0] t2_reg;
    logic signed [SQR_W-1:0]  sqr;
    logic [SQ_IN_W-1:0]       sq_next;

    // Operand pairs of the products
    always_comb
    begin
        opa[P_WX] = quat_w;  opb[P_WX] = quat_x;
        opa[P_YZ] = quat_y;  opb[P_YZ] = quat_z;
        opa[P_XX] = quat_x;  opb[P_XX] = quat_x;
        opa[P_YY] = quat_y;  opb[P_YY] = quat_y;
        opa[P_WY] = quat_w;  opb[P_WY] = quat_y;
        opa[P_ZX] = quat_z;  opb[P_ZX] = quat_x;
        opa[P_WZ] = quat_w;  opb[P_WZ] = quat_z;
        opa[P_XY] = quat_x;  opb[P_XY] = quat_y;
        opa[P_ZZ] = quat_z;  opb[P_ZZ] = quat_z;
    end

    // Each product is brought to 28 fraction bits
    for (genvar g = 0; g < NPROD; g++)
    begin : g_prod
        logic signed [2*QUAT_WIDTH-1:0] p;
        assign p = opa[g] * opb[g];
        if (FB >= 28)
        begin : g_down
            assign prod[g] = PROD_W'(p >>> (FB - 28));
        end
        else
        begin : g_up
            assign prod[g] = PROD_W'(p) <<< (28 - FB);
        end
    end

    // Sums, doublings and the clamp of the pitch sine
    always_comb
    begin
        t0_next = (TW'(prod_reg[P_WX]) + TW'(prod_reg[P_YZ])) <<< 1;
        t1_next = ONE_Q28 - ((TW'(prod_reg[P_XX]) + TW'(prod_reg[P_YY])) <<< 1);
        t3_next = (TW'(prod_reg[P_WZ]) + TW'(prod_reg[P_XY])) <<< 1;
        t4_next = ONE_Q28 - ((TW'(prod_reg[P_YY]) + TW'(prod_reg[P_ZZ])) <<< 1);
        t2_raw  = (TW'(prod_reg[P_WY]) - TW'(prod_reg[P_ZX])) <<< 1;
        if (t2_raw > ONE_Q28)
            t2_next = CLIP_W'(ONE_Q28);
        else if (t2_raw < -ONE_Q28)
            t2_next = CLIP_W'(-ONE_Q28);
        else
            t2_next = CLIP_W'(t2_raw);
    end

    // Radicand of the cosine, 1 - t^2 in Q56
    always_comb
    begin
        sqr     = SQR_W'(t2_reg) * SQR_W'(t2_reg);
        sq_next = SQ_IN_W'((SQR_W'(1) <<< 56) - sqr);
    end

    // Pipeline registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod;
            t0_reg   <= t0_next;
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            t3_reg   <= t3_next;
            t4_reg   <= t4_next;
            t0       <= t0_reg;
            t1       <= t1_reg;
            t2       <= t2_reg;
            t3       <= t3_reg;
            t4       <= t4_reg;
            sq       <= sq_next;
        end
    end

endmodule

/* sv/q2e_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// q2e_sqrt_cell: one bit of the integer square root
// Settles root bit BIT by a trial subtract from the remainder and hands the
// remainder, the partial root and a passenger payload to the next cell.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell
    import q2e_pkg::*;
#(
    parameter int BIT   = 0,
    parameter int PAY_W = 1
)
(
    input  logic               clk,
    input  logic               en,
    input  logic [SQ_IN_W-1:0] rem_in,
    input  logic [SQ_BITS-1:0] root_in,
    input  logic [PAY_W-1:0]   pay_in,
    output logic [SQ_IN_W-1:0] rem_out,
    output logic [SQ_BITS-1:0] root_out,
    output logic [PAY_W-1:0]   pay_out
);

    localparam int TRW = SQ_IN_W + 2;

    logic [TRW-1:0]     trial;
    logic [SQ_IN_W-1:0] rem_next;
    logic [SQ_BITS-1:0] root_next;

    // (root + 2^BIT)^2 - root^2 against the remainder
    always_comb
    begin
        trial = (TRW'(root_in) << (BIT + 1)) + (TRW'(1) << (2 * BIT));
        if (TRW'(rem_in) >= trial)
        begin
            rem_next  = SQ_IN_W'(TRW'(rem_in) - trial);
            root_next = root_in | (SQ_BITS'(1) << BIT);
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= rem_next;
            root_out <= root_next;
            pay_out  <= pay_in;
        end
    end

endmodule

/* sv/q2e_cordic_cell.sv */
// ----------------------------------------------------------------------------
// q2e_cordic_cell: one CORDIC vectoring micro-rotation
// Turns the vector toward the x axis by atan(2^-STAGE) and keeps the
// accumulated angle, then registers the result for the next cell.
// ----------------------------------------------------------------------------
module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [XW-1:0] x_in,
    input  logic signed [XW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    input  logic                 zero_in,
    output logic signed [XW-1:0] x_out,
    output logic signed [XW-1:0] y_out,
    output logic signed [ZW-1:0] z_out,
    output logic                 zero_out
);

    localparam logic signed [ZW-1:0] ANGLE = cordic_angle(STAGE);

    logic signed [XW-1:0] dx, dy;
    logic signed [XW-1:0] x_next, y_next;
    logic signed [ZW-1:0] z_next;

    // Rotate clockwise when y is not negative, else counterclockwise
    always_comb
    begin
        dx = x_in >>> STAGE;
        dy = y_in >>> STAGE;
        if (!y_in[XW-1])
        begin
            x_next = x_in + dy;
            y_next = y_in - dx;
            z_next = z_in + ANGLE;
        end
        else
        begin
            x_next = x_in - dy;
            y_next = y_in + dx;
            z_next = z_in - ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_out    <= x_next;
            y_out    <= y_next;
            z_out    <= z_next;
            zero_out <= zero_in;
        end
    end

endmodule

/* sv/quaternion_to_euler_angles_top.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top: unit quaternion to roll, pitch and yaw
//
//   Channel  Direction  tdata fields (low bit first)          Width
//   s_axis   in         quat_x, quat_y, quat_z, quat_w         4*QUAT_WIDTH, byte padded
//   m_axis   out        roll[15:0], pitch[30:16], yaw[46:31]   48
//
// One transfer is taken every cycle while the output register is empty or being
// read. The depth is set by the front product stages, the 29 square-root cells,
// the quarter-turn register, the CORDIC cell rows and the output register. The
// whole pipeline advances while the output register is empty or being read, so a
// stall at m_axis holds every stage in place. Reset clears only the valid bits of
// the stages.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top
    import q2e_pkg::*;
#(
    parameter int QUAT_WIDTH    = DEF_QUAT_WIDTH,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // quat_x, quat_y, quat_z, quat_w, zero fill
    input  logic [((4*QUAT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // roll (16), pitch (15), yaw (16), one zero bit
    output logic [OUT_W-1:0]                 m_axis_tdata
);

    localparam int LAT   = 3 + SQ_BITS + 1 + CORDIC_STAGES + 1;
    localparam int PAY_W = 4 * TW + CLIP_W;
    localparam int NL    = 3;
    localparam int L_ROLL = 0, L_PITCH = 1, L_YAW = 2;

    logic                 en;
    logic [LAT-1:0]       valid_reg;
    logic [LAT-1:0]       valid_next;

    logic signed [TW-1:0]     t0, t1, t3, t4;
    logic signed [CLIP_W-1:0] t2;
    logic [SQ_IN_W-1:0]       sq;

    logic [SQ_IN_W-1:0] rem_c  [SQ_BITS+1];
    logic [SQ_BITS-1:0] root_c [SQ_BITS+1];
    logic [PAY_W-1:0]   pay_c  [SQ_BITS+1];

    logic signed [TW-1:0]     r_t0, r_t1, r_t3, r_t4;
    logic signed [CLIP_W-1:0] r_t2;

    logic signed [XW-1:0] lane_x [NL];
    logic signed [XW-1:0] lane_y [NL];

    logic signed [XW-1:0] cx [NL][CORDIC_STAGES+1];
    logic signed [XW-1:0] cy [NL][CORDIC_STAGES+1];
    logic signed [ZW-1:0] cz [NL][CORDIC_STAGES+1];
    logic                 cf [NL][CORDIC_STAGES+1];

    logic signed [15:0] roll_next, yaw_next, pitch_wide;
    logic [OUT_W-1:0]   tdata_reg;

    // Pipeline advance and the valid bit of each stage
    assign en            = !valid_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = valid_reg[LAT-1];
    assign m_axis_tdata  = tdata_reg;

    always_comb
    begin
        valid_next = {valid_reg[LAT-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    // Products and atan2 operands
    q2e_front #(
        .QUAT_WIDTH (QUAT_WIDTH)
    ) u_front (
        .clk    (clk),
        .en     (en),
        .quat_x (s_axis_tdata[QUAT_WIDTH-1:0]),
        .quat_y (s_axis_tdata[2*QUAT_WIDTH-1:QUAT_WIDTH]),
        .quat_z (s_axis_tdata[3*QUAT_WIDTH-1:2*QUAT_WIDTH]),
        .quat_w (s_axis_tdata[4*QUAT_WIDTH-1:3*QUAT_WIDTH]),
        .t0     (t0),
        .t1     (t1),
        .t2     (t2),
        .t3     (t3),
        .t4     (t4),
        .sq     (sq)
    );

    // Square-root cells, one root bit each, most significant first
    assign rem_c[0]  = sq;
    assign root_c[0] = '0;
    assign pay_c[0]  = {t2, t4, t3, t1, t0};

    for (genvar k = 0; k < SQ_BITS; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(
            .BIT   (SQ_BITS - 1 - k),
            .PAY_W (PAY_W)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (rem_c[k]),
            .root_in  (root_c[k]),
            .pay_in   (pay_c[k]),
            .rem_out  (rem_c[k+1]),
            .root_out (root_c[k+1]),
            .pay_out  (pay_c[k+1])
        );
    end

    assign {r_t2, r_t4, r_t3, r_t1, r_t0} = pay_c[SQ_BITS];

    // Vectors of the three lanes
    always_comb
    begin
        lane_y[L_ROLL]  = XW'(r_t0);
        lane_x[L_ROLL]  = XW'(r_t1);
        lane_y[L_PITCH] = XW'(r_t2);
        lane_x[L_PITCH] = XW'({1'b0, root_c[SQ_BITS]});
        lane_y[L_YAW]   = XW'(r_t3);
        lane_x[L_YAW]   = XW'(r_t4);
    end

    for (genvar l = 0; l < NL; l++)
    begin : g_lane
        // Quarter turn into the right half plane, and the zero-vector flag
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cf[l][0] <= (lane_x[l] == '0) && (lane_y[l] == '0);
                if (lane_x[l][XW-1] && !lane_y[l][XW-1])
                begin
                    cx[l][0] <= lane_y[l];
                    cy[l][0] <= -lane_x[l];
                    cz[l][0] <= HALF_PI_Q29;
                end
                else if (lane_x[l][XW-1])
                begin
                    cx[l][0] <= -lane_y[l];
                    cy[l][0] <= lane_x[l];
                    cz[l][0] <= -HALF_PI_Q29;
                end
                else
                begin
                    cx[l][0] <= lane_x[l];
                    cy[l][0] <= lane_y[l];
                    cz[l][0] <= '0;
                end
            end
        end

        // Row of CORDIC cells
        for (genvar s = 0; s < CORDIC_STAGES; s++)
        begin : g_stage
            q2e_cordic_cell #(
                .STAGE (s)
            ) u_cell (
                .clk      (clk),
                .en       (en),
                .x_in     (cx[l][s]),
                .y_in     (cy[l][s]),
                .z_in     (cz[l][s]),
                .zero_in  (cf[l][s]),
                .x_out    (cx[l][s+1]),
                .y_out    (cy[l][s+1]),
                .z_out    (cz[l][s+1]),
                .zero_out (cf[l][s+1])
            );
        end
    end

    // Rounding to Q13, clamping, and the output register
    always_comb
    begin
        roll_next  = cf[L_ROLL][CORDIC_STAGES]  ? '0 :
                     angle_q13(cz[L_ROLL][CORDIC_STAGES], ROLL_LIM);
        pitch_wide = cf[L_PITCH][CORDIC_STAGES] ? '0 :
                     angle_q13(cz[L_PITCH][CORDIC_STAGES], PITCH_LIM);
        yaw_next   = cf[L_YAW][CORDIC_STAGES]   ? '0 :
                     angle_q13(cz[L_YAW][CORDIC_STAGES], ROLL_LIM);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            tdata_reg <= {1'b0, yaw_next, pitch_wide[14:0], roll_next};
    end

    // A transfer taken at the input enters the first stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    // The input is held off exactly while a result waits at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready disagrees with output stall");

    // Pitch stays within its clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[30:16]) <= 15'sd12868 &&
                           $signed(m_axis_tdata[30:16]) >= -15'sd12868))
        else $error("pitch out of range");

endmodule

/* verif/tb_quaternion_to_euler_angles_top.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_top: stream regression for the quaternion block
// Drives quaternions into s_axis, predicts roll, pitch and yaw with an
// independent fixed-point CORDIC model, and checks every m_axis transfer in
// order. Both sides idle at random, and the receiver holds off once for a long
// stretch so that the pipeline fills and stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quaternion_to_euler_angles_top
    import q2e_pkg::*;
();

    localparam int QW      = DEF_QUAT_WIDTH;
    localparam int STAGES  = DEF_CORDIC_STAGES;
    localparam int IN_W    = ((4*QW+7)/8)*8;
    localparam int N_RAND  = 1530;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } angles_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;

    logic [IN_W-1:0]   quat_queue[$];
    angles_t           angles_queue[$];
    int                mismatches = 0;
    bit                stim_done = 0;
    bit                calm = 0;
    int                hold_cycles = 0;
    int                send_gap = 0;
    int                recv_gap = 0;
    longint            cycles = 0;

    quaternion_to_euler_angles_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock and reset
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Floor shift that also holds for negative values
    function automatic longint floor_shift(input longint v, input int s);
        return v >>> s;
    endfunction

    // atan(1/n) in Q60 by the alternating series
    function automatic longint unsigned arctan_inv_q60(input longint unsigned n);
        longint unsigned p;
        longint unsigned acc;
        longint unsigned k;
        p   = (64'd1 << 60) / n;
        acc = 0;
        k   = 0;
        while (p != 0)
        begin
            if (k[0] == 1'b0)
                acc = acc + p / (2*k + 1);
            else
                acc = acc - p / (2*k + 1);
            p = p / (n*n);
            k++;
        end
        return acc;
    endfunction

    function automatic longint rotation_angle_q29(input int i);
        longint unsigned a;
        if (i == 0)
            a = 4 * arctan_inv_q60(5) - arctan_inv_q60(239);
        else
            a = arctan_inv_q60(64'd1 << i);
        return longint'((a + (64'd1 << 30)) >> 31);
    endfunction

    // Vectoring CORDIC, result in Q29
    function automatic longint vector_angle(input longint yv, input longint xv);
        longint ang;
        longint tmp;
        longint dx;
        longint dy;
        ang = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            tmp = xv;
            if (yv >= 0)
            begin
                xv = yv; yv = -tmp; ang = 2 * rotation_angle_q29(0);
            end
            else
            begin
                xv = -yv; yv = tmp; ang = -2 * rotation_angle_q29(0);
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = floor_shift(xv, i);
            dy = floor_shift(yv, i);
            if (yv >= 0)
            begin
                xv += dy; yv -= dx; ang += rotation_angle_q29(i);
            end
            else
            begin
                xv -= dy; yv += dx; ang -= rotation_angle_q29(i);
            end
        end
        return ang;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Q29 angle to Q13, rounded half away from zero, clamped to lim
    function automatic longint to_q13(input longint a, input longint lim);
        longint m;
        longint r;
        m = (a < 0) ? -a : a;
        r = (m + (64'd1 << 15)) >> 16;
        if (r > lim)
            r = lim;
        return (a < 0) ? -r : r;
    endfunction

    function automatic longint prod_q28(input longint a, input longint b);
        return (a * b) <<< (28 - 2*(QW-2));
    endfunction

    function automatic angles_t euler_from_quat(input logic [IN_W-1:0] d);
        longint qx, qy, qz, qw;
        longint sr, cr, sp, cp, sy, cy;
        longint one;
        angles_t e;
        qx  = longint'($signed(d[QW-1:0]));
        qy  = longint'($signed(d[2*QW-1:QW]));
        qz  = longint'($signed(d[3*QW-1:2*QW]));
        qw  = longint'($signed(d[4*QW-1:3*QW]));
        one = 64'd1 << 28;
        sr  = 2 * (prod_q28(qw, qx) + prod_q28(qy, qz));
        cr  = one - 2 * (prod_q28(qx, qx) + prod_q28(qy, qy));
        sp  = 2 * (prod_q28(qw, qy) - prod_q28(qz, qx));
        if (sp > one)
            sp = one;
        if (sp < -one)
            sp = -one;
        cp  = longint'(floor_sqrt((64'd1 << 56) - longint'(sp * sp)));
        sy  = 2 * (prod_q28(qw, qz) + prod_q28(qx, qy));
        cy  = one - 2 * (prod_q28(qy, qy) + prod_q28(qz, qz));
        e.roll  = 16'(to_q13(vector_angle(sr, cr), ROLL_LIM));
        e.pitch = 15'(to_q13(vector_angle(sp, cp), PITCH_LIM));
        e.yaw   = 16'(to_q13(vector_angle(sy, cy), ROLL_LIM));
        return e;
    endfunction

    function automatic logic [IN_W-1:0] pack_quat(input int qx, input int qy,
                                                  input int qz, input int qw);
        logic [IN_W-1:0] d;
        d = '0;
        d[QW-1:0]      = QW'(qx);
        d[2*QW-1:QW]   = QW'(qy);
        d[3*QW-1:2*QW] = QW'(qz);
        d[4*QW-1:3*QW] = QW'(qw);
        return d;
    endfunction

    function automatic int rand_comp();
        return $urandom_range(32768) - 16384;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Stimulus: directed corners, then unit, corner-valued and raw random quaternions
    initial
    begin
        int          qx, qy, qz, qw;
        real         rx, ry, rz, rw, nrm;
        int          corner[5];
        corner = '{-16384, -1, 0, 1, 16384};
        quat_queue.push_back(pack_quat(0, 0, 0, 16384));
        quat_queue.push_back(pack_quat(0, 0, 0, 0));
        quat_queue.push_back(pack_quat(16384, 0, 0, 0));
        quat_queue.push_back(pack_quat(0, 16384, 0, 0));
        quat_queue.push_back(pack_quat(0, 0, 16384, 0));
        quat_queue.push_back(pack_quat(11585, 0, 0, 11585));
        quat_queue.push_back(pack_quat(0, 11585, 0, 11585));
        quat_queue.push_back(pack_quat(0, -11585, 0, 11585));
        quat_queue.push_back(pack_quat(0, 0, 11585, 11585));
        quat_queue.push_back(pack_quat(0, 0, -11585, 11585));
        quat_queue.push_back(pack_quat(16384, 16384, 16384, 16384));
        quat_queue.push_back(pack_quat(-16384, -16384, -16384, -16384));
        quat_queue.push_back(pack_quat(-16384, 16384, -16384, 16384));
        quat_queue.push_back(pack_quat(16384, -16384, 16384, -16384));
        quat_queue.push_back(pack_quat(8192, 8192, 8192, 8192));
        quat_queue.push_back(pack_quat(-8192, 8192, 0, 0));
        quat_queue.push_back(pack_quat(0, -1, 0, 1));
        quat_queue.push_back(pack_quat(1, 1, 1, -1));
        quat_queue.push_back(pack_quat(0, 0, 0, -16384));
        quat_queue.push_back(pack_quat(8192, -8192, 8192, -8192));
        for (int i = 0; i < N_RAND; i++)
        begin
            if ($urandom_range(9) < 7)
            begin
                // Normalized quaternion with random direction
                rx = $itor(rand_comp()); ry = $itor(rand_comp());
                rz = $itor(rand_comp()); rw = $itor(rand_comp());
                nrm = $sqrt(rx*rx + ry*ry + rz*rz + rw*rw);
                if (nrm < 1.0)
                    nrm = 1.0;
                qx = $rtoi(rx * 16384.0 / nrm); qy = $rtoi(ry * 16384.0 / nrm);
                qz = $rtoi(rz * 16384.0 / nrm); qw = $rtoi(rw * 16384.0 / nrm);
            end
            else if ($urandom_range(1))
            begin
                qx = corner[$urandom_range(4)]; qy = corner[$urandom_range(4)];
                qz = corner[$urandom_range(4)]; qw = corner[$urandom_range(4)];
            end
            else
            begin
                qx = rand_comp(); qy = rand_comp(); qz = rand_comp(); qw = rand_comp();
            end
            quat_queue.push_back(pack_quat(qx, qy, qz, qw));
        end
    end

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                angles_queue.push_back(euler_from_quat(s_axis_tdata));
            if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap      <= send_gap - 1;
            end
            else if (quat_queue.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= quat_queue.pop_front();
                if (!calm && $urandom_range(15) == 0)
                    send_gap <= $urandom_range(8, 1);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                stim_done     <= 1'b1;
            end
        end
    end

    // Monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        angles_t got;
        angles_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = angles_t'(m_axis_tdata[46:0]);
                if (angles_queue.size() == 0)
                    report_mismatch("unexpected result transfer", longint'(m_axis_tdata), 0);
                else
                begin
                    want = angles_queue.pop_front();
                    if (got.roll !== want.roll)
                        report_mismatch("roll", got.roll, want.roll);
                    if (got.pitch !== want.pitch)
                        report_mismatch("pitch", got.pitch, want.pitch);
                    if (got.yaw !== want.yaw)
                        report_mismatch("yaw", got.yaw, want.yaw);
                end
            end
            if (hold_cycles > 0 || recv_gap > 0)
                m_axis_tready <= 1'b0;
            else
                m_axis_tready <= 1'b1;
            if (recv_gap > 0)
                recv_gap <= recv_gap - 1;
            else if (!calm && $urandom_range(11) == 0)
                recv_gap <= $urandom_range(8, 1);
        end
    end

    // One long receiver hold-off early in the random part
    always @(posedge clk)
    begin
        if (cycles == 300)
            hold_cycles <= 150;
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // Quiet tail: no idling once most items have gone
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (quat_queue.size() < 200)
            calm <= 1'b1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("quaternion_to_euler_angles_top regression: fail");
            $finish;
        end
    end

    // End of run
    initial
    begin
        wait (stim_done);
        wait (angles_queue.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && angles_queue.size() == 0)
            $display("quaternion_to_euler_angles_top regression: pass");
        else
            $display("quaternion_to_euler_angles_top regression: fail");
        $finish;
    end

endmodule
